>>> rtl/core/sgta_pkg.sv
// ----------------------------------------------------------------------------
// sgta_pkg
// Shared types and constants of the strided tensor gather address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sgta_pkg;

	localparam int OFFSET_W = 50;
	localparam int COUNT_W  = 64;
	localparam int TDATA_W  = ((OFFSET_W + COUNT_W + 7) / 8) * 8;
	localparam int IN_W     = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int RANK_W     = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_RANK    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTENTS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE0 = 3'd2;

	typedef struct packed {
		logic last;
		logic err;
	} step_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/sgta_cfg.sv
// ----------------------------------------------------------------------------
// sgta_cfg
// Configuration registers with rank clamping and extent normalization.
// ----------------------------------------------------------------------------
`default_nettype none

module sgta_cfg
	import sgta_pkg::*;
#(
	parameter int MAX_DIMS    = 4,
	parameter int EXTENT_BITS = 16,
	parameter int STRIDE_BITS = 32
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]                     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]                    cfg_data,
	output logic      [MAX_DIMS-1:0]                      used,
	output logic      [MAX_DIMS-1:0][EXTENT_BITS-1:0]     extent,
	output logic      [MAX_DIMS-1:0][STRIDE_BITS-1:0]     stride
);

	logic [RANK_W-1:0]                     rank_q;
	logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  extent_q;
	logic [MAX_DIMS-1:0][STRIDE_BITS-1:0]  stride_q;
	logic [RANK_W-1:0]                     rank_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= RANK_W'(1);
		end else if (cfg_we && cfg_index == CFG_RANK) begin
			rank_q <= cfg_data[RANK_W-1:0];
		end
	end

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				extent_q[d] <= EXTENT_BITS'(1);
				stride_q[d] <= STRIDE_BITS'(1);
			end else begin
				if (cfg_we && cfg_index == CFG_EXTENTS) begin
					extent_q[d] <= cfg_data[d*EXTENT_BITS +: EXTENT_BITS];
				end
				if (cfg_we && cfg_index == CFG_IDX_W'(CFG_STRIDE0 + d)) begin
					stride_q[d] <= cfg_data[STRIDE_BITS-1:0];
				end
			end
		end

		assign extent[d] = (extent_q[d] == '0) ? EXTENT_BITS'(1) : extent_q[d];
		assign used[d]   = (RANK_W'(d) < rank_eff);
	end

	always_comb begin
		if (rank_q == '0) begin
			rank_eff = RANK_W'(1);
		end else if (rank_q > RANK_W'(MAX_DIMS)) begin
			rank_eff = RANK_W'(MAX_DIMS);
		end else begin
			rank_eff = rank_q;
		end
	end

	assign stride = stride_q;

endmodule

`default_nettype wire

>>> rtl/core/sgta_odometer.sv
// ----------------------------------------------------------------------------
// sgta_odometer
// Per-dimension index counters, element count and traversal state.
// ----------------------------------------------------------------------------
`default_nettype none

module sgta_odometer
	import sgta_pkg::*;
#(
	parameter int MAX_DIMS    = 4,
	parameter int EXTENT_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  accept,
	input  wire logic                                  begin_req,
	input  wire logic [MAX_DIMS-1:0]                   used,
	input  wire logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  extent,
	output logic      [MAX_DIMS-1:0][EXTENT_BITS-1:0]  idx_q,
	output logic      [COUNT_W-1:0]                    flat_q,
	output logic                                       active_q,
	output step_flags_t                                flags_s1
);

	logic [MAX_DIMS-1:0][EXTENT_BITS:0]    idx_p1;
	logic [MAX_DIMS-1:0]                   wrap;
	logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  nxt;
	logic                                  carry;
	logic                                  at_end;

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_inc
		assign idx_p1[d] = {1'b0, idx_q[d]} + (EXTENT_BITS+1)'(1);
		assign wrap[d]   = (idx_p1[d] >= {1'b0, extent[d]});
	end

	always_comb begin
		carry  = 1'b1;
		at_end = 1'b1;
		for (int d = MAX_DIMS - 1; d >= 0; d--) begin
			nxt[d] = idx_q[d];
			if (used[d]) begin
				if (carry) begin
					nxt[d] = wrap[d] ? '0 : idx_p1[d][EXTENT_BITS-1:0];
				end
				carry = carry & wrap[d];
			end
		end
		if (begin_req) begin
			nxt = '0;
		end
		for (int d = 0; d < MAX_DIMS; d++) begin
			if (used[d] && nxt[d] < extent[d] - EXTENT_BITS'(1)) begin
				at_end = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			flat_q   <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (begin_req) begin
				idx_q    <= nxt;
				flat_q   <= '0;
				active_q <= !at_end;
			end else if (active_q) begin
				idx_q    <= nxt;
				flat_q   <= flat_q + COUNT_W'(1);
				active_q <= !at_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1.err  <= !begin_req && !active_q;
			flags_s1.last <= (begin_req || active_q) && at_end;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sgta_lane.sv
// ----------------------------------------------------------------------------
// sgta_lane
// One dimension's index times stride product, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sgta_lane
	import sgta_pkg::*;
#(
	parameter int EXTENT_BITS = 16,
	parameter int STRIDE_BITS = 32
) (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic                    keep,
	input  wire logic [EXTENT_BITS-1:0]  idx,
	input  wire logic [STRIDE_BITS-1:0]  stride,
	output logic      [OFFSET_W-1:0]     prod_s2
);

	localparam int PROD_W = EXTENT_BITS + STRIDE_BITS;

	logic [PROD_W-1:0] prod;

	assign prod = {{STRIDE_BITS{1'b0}}, idx} * {{EXTENT_BITS{1'b0}}, stride};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= keep ? OFFSET_W'(prod) : '0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/strided_tensor_gather_addresses.sv
// ----------------------------------------------------------------------------
// strided_tensor_gather_addresses
// Source offset and dense destination index generator for strided tensors.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle unless m_tready stalls the
// output, and returns one result per transaction: the odometer stage updates
// the index counters, the lane stage forms one index times stride product per
// dimension in parallel, and the output stage adds the products. A begin_req
// of 1 restarts the walk at element zero; a 0 advances it, with the last used
// dimension moving fastest. The final element carries tlast, and an advance
// with no walk running returns tuser set and zero data. The user must write
// configuration while no transaction is in flight; the block does not check.
`default_nettype none

module strided_tensor_gather_addresses
	import sgta_pkg::*;
#(
	parameter int MAX_DIMS    = 4,
	parameter int EXTENT_BITS = 16,
	parameter int STRIDE_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// Fields from bit 0: begin_req.
	input  wire logic [IN_W-1:0]        s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// Fields from bit 0: source_offset, dest_index.
	output logic      [TDATA_W-1:0]     m_tdata,
	output logic                        m_tlast,
	// Fields from bit 0: sequence_error.
	output logic                        m_tuser
);

	logic [MAX_DIMS-1:0]                   used;
	logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  extent;
	logic [MAX_DIMS-1:0][STRIDE_BITS-1:0]  stride;
	logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  idx_q;
	logic [COUNT_W-1:0]                    flat_q;
	logic                                  active_q;
	step_flags_t                           flags_s1;
	step_flags_t                           flags_s2;
	step_flags_t                           flags_s3;
	logic [MAX_DIMS-1:0][OFFSET_W-1:0]     prod_s2;
	logic [COUNT_W-1:0]                    flat_s2;
	logic [COUNT_W-1:0]                    flat_s3;
	logic [OFFSET_W-1:0]                   offset_s3;
	logic [OFFSET_W-1:0]                   offset_sum;
	logic                                  valid_s1;
	logic                                  valid_s2;
	logic                                  valid_s3;
	logic                                  adv2;
	logic                                  adv3;
	logic                                  accept;

	assign adv3     = !valid_s3 || m_tready;
	assign adv2     = !valid_s2 || adv3;
	assign s_tready = !valid_s1 || adv2;
	assign accept   = s_tvalid && s_tready;

	sgta_cfg #(
		.MAX_DIMS    (MAX_DIMS),
		.EXTENT_BITS (EXTENT_BITS),
		.STRIDE_BITS (STRIDE_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.used      (used),
		.extent    (extent),
		.stride    (stride)
	);

	sgta_odometer #(
		.MAX_DIMS    (MAX_DIMS),
		.EXTENT_BITS (EXTENT_BITS)
	) u_odometer (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.begin_req (s_tdata[0]),
		.used      (used),
		.extent    (extent),
		.idx_q     (idx_q),
		.flat_q    (flat_q),
		.active_q  (active_q),
		.flags_s1  (flags_s1)
	);

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
		sgta_lane #(
			.EXTENT_BITS (EXTENT_BITS),
			.STRIDE_BITS (STRIDE_BITS)
		) u_lane (
			.clk     (clk),
			.en      (adv2),
			.keep    (used[d] && !flags_s1.err),
			.idx     (idx_q[d]),
			.stride  (stride[d]),
			.prod_s2 (prod_s2[d])
		);
	end

	always_comb begin
		offset_sum = '0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			offset_sum = offset_sum + prod_s2[d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			flat_s2  <= flags_s1.err ? '0 : flat_q;
			flags_s2 <= flags_s1;
		end
		if (adv3) begin
			offset_s3 <= offset_sum;
			flat_s3   <= flat_s2;
			flags_s3  <= flags_s2;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = {{(TDATA_W - OFFSET_W - COUNT_W){1'b0}}, flat_s3, offset_s3};
	assign m_tlast  = flags_s3.last;
	assign m_tuser  = flags_s3.err;

	a_idle_advance_errs: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !s_tdata[0] && !active_q |=> valid_s1 && flags_s1.err && !flags_s1.last)
		else $error("advance with no walk running did not raise the error flag");

	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && flags_s1.last |-> !active_q)
		else $error("walk still running after its final element");

	a_begin_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tdata[0] |=> flat_q == '0 && !flags_s1.err)
		else $error("start transaction did not clear the element count");

endmodule

`default_nettype wire
